/* rtl/core/spq_pkg.sv */
package spq_pkg;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
    logic        [7:0]  priority_req;
  } spq_in_t;

  typedef struct packed {
    spq_status_e        status;
    logic signed [31:0] out_value;
    logic        [7:0]  out_priority;
    logic        [3:0]  occupancy;
  } spq_out_t;

  typedef struct packed {
    logic               valid;
    logic        [7:0]  prio;
    logic signed [31:0] value;
  } spq_entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  logic               keep_prev_i,
  input  spq_pkg::spq_entry_t new_i,
  input  spq_pkg::spq_entry_t prev_i,
  input  spq_pkg::spq_entry_t next_i,
  output logic               keep_o,
  output spq_pkg::spq_entry_t entry_o
);
  import spq_pkg::*;

  logic               valid_q;
  logic        [7:0]  prio_q;
  logic signed [31:0] value_q;
  spq_entry_t         entry;
  spq_entry_t         entry_d;

  assign entry = {valid_q, prio_q, value_q};

  // entry stays where it is if it outranks or ties the incoming one
  assign keep_o = entry.valid && (entry.prio >= new_i.prio);

  always_comb begin
    entry_d = entry;
    if (ctrl_i.deq) begin
      entry_d = next_i;
    end else if (ctrl_i.enq && !keep_o) begin
      if (keep_prev_i) begin
        entry_d = new_i;
      end else begin
        entry_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q  <= entry_d.prio;
    value_q <= entry_d.value;
  end

  assign entry_o = entry;

endmodule

/* rtl/core/sorted_priority_queue_top.sv */
// Bounded priority queue of DEPTH entries held in a row of cells sorted by
// descending priority, ties leaving in arrival order. Every operation
// (enqueue or dequeue) is one item in and exactly one result item out; all
// cells compare against the incoming priority and shift in parallel, so an
// item is taken every cycle and its result appears in the next cycle in the
// output register. The input stalls only while that register holds a result
// that the receiver is stalling. An enqueue into a full queue returns status
// full and a dequeue from an empty one returns status empty, both leaving
// the contents unchanged. occupancy reports the live count after the item.
module sorted_priority_queue_top #(
  parameter int DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  spq_pkg::spq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          in_accept;
  logic          is_deq;
  logic          full;
  logic          empty;
  spq_ctrl_t     ctrl;
  spq_entry_t    new_entry;
  spq_entry_t    cells   [DEPTH];
  logic          keep    [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  spq_out_t      out_q, out_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_deq     = (in_data_i.operation == OP_DEQ);
  assign full       = (cnt_q == CW'(DEPTH));
  assign empty      = (cnt_q == '0);

  assign ctrl.enq = in_accept && !is_deq && !full;
  assign ctrl.deq = in_accept && is_deq && !empty;

  assign new_entry.valid = 1'b1;
  assign new_entry.prio  = in_data_i.priority_req;
  assign new_entry.value = in_data_i.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t prev_e;
    spq_entry_t next_e;
    logic       keep_prev;
    if (i == 0) begin : g_first
      assign prev_e    = new_entry;
      assign keep_prev = 1'b1;
    end else begin : g_mid
      assign prev_e    = cells[i-1];
      assign keep_prev = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cells[i+1];
    end
    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .keep_prev_i(keep_prev),
      .new_i      (new_entry),
      .prev_i     (prev_e),
      .next_i     (next_e),
      .keep_o     (keep[i]),
      .entry_o    (cells[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.enq) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctrl.deq) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (in_accept) begin
      out_valid_d        = 1'b1;
      out_d.status       = ST_DONE;
      out_d.out_value    = '0;
      out_d.out_priority = '0;
      out_d.occupancy    = 4'(cnt_d);
      if (is_deq) begin
        if (empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.out_value    = cells[0].value;
          out_d.out_priority = cells[0].prio;
        end
      end else if (full) begin
        out_d.status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("live count above depth");

  a_cnt_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(cnt_q))
    else $error("live count disagrees with cell valid bits");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_deq && empty |=> out_q.status == ST_EMPTY)
    else $error("dequeue from empty queue not reported");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !is_deq && full |=> $stable(valid_vec) && out_q.status == ST_FULL)
    else $error("rejected enqueue changed the queue");

  for (genvar j = 0; j < DEPTH - 1; j++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cells[j+1].valid |-> cells[j].valid && (cells[j].prio >= cells[j+1].prio))
      else $error("cells out of order");
  end

endmodule

/* tb/spq_checker.sv */
`timescale 1ns / 100ps

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  spq_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  spq_out_t out_data_i,
  output int       errors_o,
  output int       pending_o,
  output int       results_o,
  output int       full_rejects_o,
  output int       empty_rejects_o
);

  typedef struct packed {
    logic        [7:0]  prio;
    logic signed [31:0] value;
  } queued_entry_t;

  // live entries, index 0 is served next
  queued_entry_t held_entries[$];
  spq_out_t      expected_results[$];

  int error_count   = 0;
  int pending_items = 0;
  int checked_count = 0;
  int full_count    = 0;
  int empty_count   = 0;

  spq_out_t got;
  spq_out_t want;

  assign errors_o        = error_count;
  assign pending_o       = pending_items;
  assign results_o       = checked_count;
  assign full_rejects_o  = full_count;
  assign empty_rejects_o = empty_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic spq_out_t apply_operation(input spq_in_t item);
    spq_out_t      res;
    queued_entry_t entry;
    int            pos;
    res = '0;
    res.status = ST_DONE;
    if (item.operation == OP_ENQ) begin
      if (held_entries.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio >= item.priority_req) pos++;
        entry.prio  = item.priority_req;
        entry.value = item.value;
        held_entries.insert(pos, entry);
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        entry = held_entries.pop_front();
        res.out_value    = entry.value;
        res.out_priority = entry.prio;
      end
    end
    res.occupancy = 4'(held_entries.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_entries.delete();
      expected_results.delete();
      pending_items = 0;
    end else begin
      // a result never leaves in the cycle its item is taken, so compare before predicting
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item pending");
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (want.status == ST_FULL) full_count++;
          if (want.status == ST_EMPTY) empty_count++;
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.out_value !== want.out_value)
            report_mismatch($sformatf("out_value got %h want %h",
                                      got.out_value, want.out_value));
          if (got.out_priority !== want.out_priority)
            report_mismatch($sformatf("out_priority got %0d want %0d",
                                      got.out_priority, want.out_priority));
          if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      got.occupancy, want.occupancy));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_operation(in_data_i));
      end
      pending_items = expected_results.size();
    end
  end

endmodule

/* tb/tb_sorted_priority_queue_top.sv */
`timescale 1ns / 100ps

module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int DEPTH        = 8;
  localparam int RANDOM_ITEMS = 1030;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  spq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spq_out_t out_data;

  logic calm = 1'b0;
  int   items_sent = 0;
  int   error_count;
  int   pending_count;
  int   results_count;
  int   full_rejects;
  int   empty_rejects;

  always #10 clk = ~clk;

  sorted_priority_queue_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  spq_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .errors_o       (error_count),
    .pending_o      (pending_count),
    .results_o      (results_count),
    .full_rejects_o (full_rejects),
    .empty_rejects_o(empty_rejects)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 17);
  end

  function automatic spq_in_t make_item(input logic op, input logic [31:0] val,
                                        input logic [7:0] prio);
    spq_in_t item;
    item.operation    = op;
    item.value        = val;
    item.priority_req = prio;
    return item;
  endfunction

  task automatic send_item(input spq_in_t item);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    spq_in_t item;
    int      enq_bias;
    enq_bias = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty, extremes, ties in arrival order, full, drain, empty again
    send_item(make_item(OP_DEQ, 32'hffffffff, 8'hff));
    send_item(make_item(OP_ENQ, 32'h7fffffff, 8'd0));
    send_item(make_item(OP_ENQ, 32'h80000000, 8'd255));
    send_item(make_item(OP_ENQ, 32'h00000000, 8'd128));
    send_item(make_item(OP_ENQ, 32'hffffffff, 8'd128));
    send_item(make_item(OP_ENQ, 32'h00000001, 8'd0));
    send_item(make_item(OP_ENQ, 32'h55555555, 8'd255));
    send_item(make_item(OP_ENQ, 32'haaaaaaaa, 8'd1));
    send_item(make_item(OP_ENQ, 32'd123, 8'd128));
    send_item(make_item(OP_ENQ, 32'hfffffffb, 8'd255));
    for (int k = 0; k < DEPTH; k++) begin
      send_item(make_item(OP_DEQ, $urandom, 8'($urandom)));
    end
    send_item(make_item(OP_DEQ, 32'h12345678, 8'h5a));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 400 && n < 600);
      if (n % 60 == 0) enq_bias = $urandom_range(20, 80);
      item.operation    = ($urandom_range(0, 99) < enq_bias) ? OP_ENQ : OP_DEQ;
      item.value        = $urandom;
      item.priority_req = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      send_item(item);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);

    $display("sent %0d items, checked %0d results", items_sent, results_count);
    $display("enqueues refused as full: %0d, dequeues refused as empty: %0d",
             full_rejects, empty_rejects);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
